### rtl/core/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg: shared types and constants for the text find and replace stream
// Sizes of the lookahead window, line limit, op queue and config registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfr_pkg;

  localparam int ByteW       = 8;
  localparam int MaxPattern  = 8;
  localparam int RepMax      = 8;
  localparam int WinDepth    = MaxPattern + 1;
  localparam int FillW       = $clog2(WinDepth + 1);
  localparam int LenW        = 4;
  localparam int TextW       = 64;
  localparam int LineLimit   = 80;
  localparam int CntW        = $clog2(LineLimit + 1);
  localparam int RepIdxW     = $clog2(RepMax);
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);
  localparam int CfgIdxW     = 3;

  // Config register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPatternBytes     = 3'd0,
    RegPatternLength    = 3'd1,
    RegReplacementBytes = 3'd2,
    RegReplacementLen   = 3'd3,
    RegWholeWord        = 3'd4
  } cfg_reg_e;

  // Work items from the front to the back
  typedef enum logic [1:0] {
    OpLit = 2'd0,   // emit one literal byte
    OpRep = 2'd1,   // emit the replacement text
    OpEnd = 2'd2    // close the line
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [ByteW-1:0]  ch;
  } tfr_op_t;

  typedef struct packed {
    logic [TextW-1:0] pattern_bytes;
    logic [LenW-1:0]  pattern_length;
    logic [TextW-1:0] replacement_bytes;
    logic [LenW-1:0]  replacement_length;
    logic             whole_word_mode;
  } tfr_cfg_t;

endpackage

`default_nettype wire

### rtl/core/tfr_front.sv
// ----------------------------------------------------------------------------
// tfr_front: lookahead window and match decision
// Accepts line bytes, holds up to one pattern plus one byte of lookahead and
// resolves the window head into literal, replacement or end-of-line ops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfr_front
  import tfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tfr_cfg_t         cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_char_i,
  input  wire logic             in_last_i,
  output logic                  op_valid_o,
  input  wire logic             op_ready_i,
  output tfr_op_t               op_o,
  output logic                  line_open_o
);

  function automatic logic is_alnum(logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  logic [ByteW-1:0] win_q [WinDepth];
  logic [FillW-1:0] fill_q;
  logic             prev_alnum_q;
  logic             flush_q;
  logic             line_open_q;

  logic [ByteW-1:0] w  [WinDepth];
  logic [ByteW-1:0] nw [WinDepth];
  logic [FillW-1:0] f;
  logic [FillW-1:0] p;
  logic [FillW-1:0] n;
  logic             accept;
  logic             at_end;
  logic             do_res;
  logic             end_push;
  logic             bytes_ok;
  logic             match;
  logic             word_ok;

  assign in_ready_o  = !flush_q && op_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign line_open_o = line_open_q;

  // Window as seen this cycle, with the incoming byte appended
  always_comb begin
    for (int k = 0; k < WinDepth; k++) begin
      w[k] = (accept && fill_q == FillW'(k)) ? in_char_i : win_q[k];
    end
    f = accept ? fill_q + FillW'(1) : fill_q;
  end

  // Head resolution
  always_comb begin
    p = (cfg_i.pattern_length > LenW'(MaxPattern)) ? FillW'(MaxPattern)
                                                    : FillW'(cfg_i.pattern_length);
    at_end   = flush_q || (accept && in_last_i);
    do_res   = accept ? (in_last_i || (f >= p + FillW'(1)))
                      : (flush_q && op_ready_i && fill_q != '0);
    end_push = flush_q && op_ready_i && fill_q == '0;

    bytes_ok = 1'b1;
    for (int k = 0; k < MaxPattern; k++) begin
      if (FillW'(k) < p && w[k] != cfg_i.pattern_bytes[k*ByteW +: ByteW]) begin
        bytes_ok = 1'b0;
      end
    end

    if (prev_alnum_q) begin
      word_ok = 1'b0;
    end else if (f > p) begin
      word_ok = !is_alnum(w[p]);
    end else begin
      word_ok = at_end;
    end

    match = (p != '0) && (f >= p) && bytes_ok && (!cfg_i.whole_word_mode || word_ok);
    n     = match ? p : FillW'(1);
  end

  // Window after dropping the resolved bytes
  always_comb begin
    logic [FillW:0] src;
    for (int k = 0; k < WinDepth; k++) begin
      src   = (FillW + 1)'(k) + {1'b0, n};
      nw[k] = (src < (FillW + 1)'(WinDepth)) ? w[src[FillW-1:0]] : w[k];
    end
  end

  assign op_valid_o = do_res || end_push;
  assign op_o.kind  = end_push ? OpEnd : (match ? OpRep : OpLit);
  assign op_o.ch    = w[0];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      prev_alnum_q <= 1'b0;
      flush_q      <= 1'b0;
      line_open_q  <= 1'b0;
    end else begin
      if (do_res) begin
        fill_q       <= f - n;
        prev_alnum_q <= match ? is_alnum(w[p - FillW'(1)]) : is_alnum(w[0]);
      end else if (accept) begin
        fill_q <= f;
      end
      if (accept) begin
        line_open_q <= 1'b1;
        if (in_last_i) begin
          flush_q <= 1'b1;
        end
      end
      if (end_push) begin
        flush_q      <= 1'b0;
        fill_q       <= '0;
        prev_alnum_q <= 1'b0;
        line_open_q  <= 1'b0;
      end
    end
  end

  // Window bytes
  always_ff @(posedge clk_i) begin
    if (do_res) begin
      win_q <= nw;
    end else if (accept) begin
      win_q <= w;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tfr_fifo.sv
// ----------------------------------------------------------------------------
// tfr_fifo: op queue between front and back
// Small register queue so that the front keeps taking bytes while the back
// expands a replacement or waits on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfr_fifo
  import tfr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire tfr_op_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         not_empty_o,
  output tfr_op_t      head_o
);

  tfr_op_t          mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o      = count_q == QCntW'(QueueDepth);
  assign not_empty_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tfr_back.sv
// ----------------------------------------------------------------------------
// tfr_back: op execution and output stage
// Expands replacements a byte per cycle unless the output stalls, enforces the
// line limit, holds a byte back so the final beat carries last and truncation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfr_back
  import tfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tfr_cfg_t         cfg_i,
  input  wire logic             op_valid_i,
  input  wire tfr_op_t          op_i,
  output logic                  op_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_char_o,
  output logic                  out_last_o,
  output logic                  out_trunc_o
);

  logic [CntW-1:0]    count_q;
  logic               dropped_q;
  logic               held_valid_q;
  logic [ByteW-1:0]   held_q;
  logic [RepIdxW-1:0] rep_idx_q;
  logic               out_valid_q;
  logic [ByteW-1:0]   out_char_q;
  logic               out_last_q;
  logic               out_trunc_q;

  logic               out_can;
  logic               act;
  logic [LenW-1:0]    r;
  logic               prod;
  logic [ByteW-1:0]   prod_ch;
  logic               keep;
  logic               close;
  logic               rep_done;

  assign out_can = !out_valid_q || out_ready_i;
  assign act     = op_valid_i && out_can;
  assign r       = (cfg_i.replacement_length > LenW'(RepMax)) ? LenW'(RepMax)
                                                              : cfg_i.replacement_length;
  assign rep_done = ({1'b0, rep_idx_q} == r - LenW'(1));

  // Op decode
  always_comb begin
    prod     = 1'b0;
    prod_ch  = op_i.ch;
    close    = 1'b0;
    op_pop_o = 1'b0;
    unique case (op_i.kind)
      OpLit: begin
        prod     = act;
        op_pop_o = act;
      end
      OpRep: begin
        prod_ch = cfg_i.replacement_bytes[rep_idx_q*ByteW +: ByteW];
        if (r == '0) begin
          op_pop_o = act;
        end else begin
          prod     = act;
          op_pop_o = act && rep_done;
        end
      end
      OpEnd: begin
        close    = act;
        op_pop_o = act;
      end
      default: begin
        op_pop_o = act;
      end
    endcase
    keep = prod && (count_q < CntW'(LineLimit));
  end

  // Line state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      dropped_q    <= 1'b0;
      held_valid_q <= 1'b0;
      rep_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (act && op_i.kind == OpRep && r != '0) begin
        rep_idx_q <= rep_done ? '0 : rep_idx_q + RepIdxW'(1);
      end
      if (prod && !keep) begin
        dropped_q <= 1'b1;
      end
      if (keep) begin
        count_q      <= count_q + CntW'(1);
        held_valid_q <= 1'b1;
        if (held_valid_q) begin
          out_valid_q <= 1'b1;
        end
      end
      if (close) begin
        out_valid_q  <= 1'b1;
        count_q      <= '0;
        dropped_q    <= 1'b0;
        held_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (keep) begin
      held_q <= prod_ch;
      if (held_valid_q) begin
        out_char_q  <= held_q;
        out_last_q  <= 1'b0;
        out_trunc_q <= 1'b0;
      end
    end
    if (close) begin
      out_char_q  <= held_valid_q ? held_q : '0;
      out_last_q  <= 1'b1;
      out_trunc_q <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_trunc_o = out_trunc_q;

endmodule

`default_nettype wire

### rtl/core/text_find_replace_stream_top.sv
// ----------------------------------------------------------------------------
// text_find_replace_stream_top: streaming find and replace over text lines
// Config registers, front window/match stage, op queue and output back end.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and sustains one byte per cycle while bytes
// pass through unchanged and the output is ready; a match occupies the back
// end while it expands the replacement, and the input backs up through the
// four-entry op queue meanwhile. After the last byte of a line the front
// resolves the rest of its lookahead window, one head per cycle while the op
// queue has room, then closes the line; s_axis_tready stays low until the
// line is closed, and also while the op queue is full. A result passes
// through the op queue and the back end's output register, and each kept
// byte waits in the hold register until the next kept byte or the line
// close; empty replacements and bytes dropped at the line limit occupy the
// back end without giving a result. Config writes are always accepted; one
// that lands while a line is open is dropped, so write config only once the
// last result of a line has gone out.
`timescale 1ns / 1ps
`default_nettype none

module text_find_replace_stream_top
  import tfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [TextW-1:0]   cfg_data_i,
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] in_char
  input  wire logic               s_axis_tlast,
  // output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [7:0]              m_axis_tdata,   // [7:0] out_char
  output logic                    m_axis_tlast,
  output logic                    m_axis_tuser    // [0] truncated
);

  tfr_cfg_t cfg_q;
  logic     line_open;
  logic     op_valid;
  tfr_op_t  op;
  logic     q_full;
  logic     q_not_empty;
  tfr_op_t  q_head;
  logic     q_pop;

  assign cfg_ready_o = 1'b1;

  // Config registers, frozen while a line is open
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes      <= '0;
      cfg_q.pattern_length     <= LenW'(1);
      cfg_q.replacement_bytes  <= '0;
      cfg_q.replacement_length <= '0;
      cfg_q.whole_word_mode    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o && !line_open) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegPatternBytes:     cfg_q.pattern_bytes      <= cfg_data_i;
        RegPatternLength:    cfg_q.pattern_length     <= cfg_data_i[LenW-1:0];
        RegReplacementBytes: cfg_q.replacement_bytes  <= cfg_data_i;
        RegReplacementLen:   cfg_q.replacement_length <= cfg_data_i[LenW-1:0];
        RegWholeWord:        cfg_q.whole_word_mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .op_valid_o  (op_valid),
    .op_ready_i  (!q_full),
    .op_o        (op),
    .line_open_o (line_open)
  );

  tfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (op_valid),
    .push_data_i (op),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .head_o      (q_head)
  );

  tfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (q_not_empty),
    .op_i        (q_head),
    .op_pop_o    (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_trunc_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

### rtl/core/tfr_checker.sv
// ----------------------------------------------------------------------------
// tfr_checker: port-level checks for the find and replace stream
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfr_checker
  import tfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  input  wire logic               s_axis_tready,
  input  wire logic               s_axis_tlast,
  input  wire logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  input  wire logic [7:0]         m_axis_tdata,
  input  wire logic               m_axis_tlast,
  input  wire logic               m_axis_tuser
);

  logic [CntW-1:0] out_cnt_q;
  logic            out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Output transfers in the current line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (out_xfer) begin
      out_cnt_q <= m_axis_tlast ? '0 : out_cnt_q + CntW'(1);
    end
  end

  // Truncation is only reported on the closing result
  a_trunc_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("truncation flag without tlast");

  // Line limit holds on the output
  a_line_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> out_cnt_q < CntW'(LineLimit))
    else $error("line longer than the limit");

  // Window drain after a last byte holds the input off
  a_drain_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during line drain");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output changed while stalled");

endmodule

bind text_find_replace_stream_top tfr_checker u_tfr_checker (.*);

`default_nettype wire
